// ===== hdl/greedy_graph_coloring_macros.svh =====
// ----------------------------------------------------------------------------
// Greedy graph coloring assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_COLORING_MACROS_SVH
`define GREEDY_GRAPH_COLORING_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define GGC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ggc assertion failed");

// Check that an expression is never true outside reset.
`define GGC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ggc forbidden condition seen");

`else

`define GGC_ASSERT(lbl, clk, rst_n, prop)
`define GGC_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/ggc_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy graph coloring package
// Item types, command codes, sequencer states and mark-unit control.
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned VtxW    = 8;
  localparam int unsigned ColorW  = 9;
  localparam int unsigned GroupW  = 16;

  localparam logic [ColorW-1:0] CountMax = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_NEIGHBOR = 2'd1,
    CMD_ASSIGN   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FIND,
    ST_READ_OLD,
    ST_UPD_OLD,
    ST_UPD_NEW
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [VtxW-1:0] vertex;
    logic [VtxW-1:0] neighbor;
  } in_item_t;

  typedef struct packed {
    logic [VtxW-1:0]   colored_vertex;
    logic [ColorW-1:0] color;
    logic [ColorW-1:0] color_count;
    logic [ColorW-1:0] colors_used;
  } out_item_t;

  typedef struct packed {
    logic              clr;
    logic              set;
    logic [ColorW-1:0] set_color;
    logic              find;
  } mark_ctrl_t;

endpackage

// ===== hdl/greedy_graph_coloring.sv =====
// ----------------------------------------------------------------------------
// Greedy graph coloring
// First-fit vertex coloring over a color store and a per-color count store.
// ----------------------------------------------------------------------------
//  Channel | Handshake                | Payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o  | in_data_i  (cmd, vertex, neighbor)
//  out     | out_valid_o / out_stall_i| out_data_o (vertex, color, counts)
//
//  Neighbor items transfer one per cycle: a color-store read, then a mark set.
//  Assign steps through group search, old-color read, count decrement and count
//  increment (the count store has one read and one write port).
//  Clear and reset run a sweep over both stores; no input transfers during it.
//  A result waits in the output register; assign holds its last step while
//  an earlier result is still stalled.
// ----------------------------------------------------------------------------
`include "greedy_graph_coloring_macros.svh"

module greedy_graph_coloring #(
  parameter int MAX_VERTICES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ggc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ggc_pkg::out_item_t out_data_o
);

  localparam int unsigned MaxV      = MAX_VERTICES;
  localparam int unsigned NumVert   = (MaxV < 256) ? MaxV : 256;
  localparam int unsigned NumColors = NumVert + 2;
  localparam int unsigned VAW       = $clog2(NumVert);
  localparam int unsigned CAW       = $clog2(NumColors);
  localparam logic [CAW-1:0] SweepLast = CAW'(NumColors - 1);

  localparam int unsigned CW = ggc_pkg::ColorW;

  ggc_pkg::state_e     state_q, state_d;
  logic [CAW-1:0]      sweep_q, sweep_d;
  logic [ggc_pkg::VtxW-1:0] vtx_q;
  logic                vtx_ok_q;
  logic                nb_pend_q;
  logic [CW-1:0]       color_q, old_q, dec_q, max_q;
  logic                fwd_q;
  logic                out_valid_q;
  ggc_pkg::out_item_t  out_q;

  logic                accept;
  logic                nb_ok;
  logic                finish;
  logic                dec_ok;
  logic [CW-1:0]       cnt_base, new_cnt, max_new;

  logic                vc_we;
  logic [VAW-1:0]      vc_waddr, vc_raddr;
  logic [CW-1:0]       vc_wdata, vc_rdata;
  logic                cc_we;
  logic [CAW-1:0]      cc_waddr, cc_raddr;
  logic [CW-1:0]       cc_wdata, cc_rdata;

  ggc_pkg::mark_ctrl_t mark_ctrl;
  logic [CW-1:0]       free_color;

  assign in_stall_o = (state_q != ggc_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign nb_ok      = 32'(in_data_i.neighbor) < MaxV;
  assign finish     = !(out_valid_q && out_stall_i);

  assign dec_ok   = (old_q != '0) && (32'(old_q) < NumColors) && (cc_rdata != '0);
  assign cnt_base = fwd_q ? dec_q : cc_rdata;
  assign new_cnt  = (cnt_base == ggc_pkg::CountMax) ? cnt_base : cnt_base + CW'(1);
  assign max_new  = (color_q > max_q) ? color_q : max_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ggc_pkg::ST_SWEEP: begin
        if (sweep_q == SweepLast) state_d = ggc_pkg::ST_IDLE;
      end
      ggc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == ggc_pkg::CMD_CLEAR)       state_d = ggc_pkg::ST_SWEEP;
          else if (in_data_i.cmd == ggc_pkg::CMD_ASSIGN) state_d = ggc_pkg::ST_FIND;
        end
      end
      ggc_pkg::ST_FIND:     state_d = vtx_ok_q ? ggc_pkg::ST_READ_OLD : ggc_pkg::ST_IDLE;
      ggc_pkg::ST_READ_OLD: state_d = ggc_pkg::ST_UPD_OLD;
      ggc_pkg::ST_UPD_OLD:  state_d = ggc_pkg::ST_UPD_NEW;
      ggc_pkg::ST_UPD_NEW: begin
        if (finish) state_d = ggc_pkg::ST_IDLE;
      end
      default: state_d = ggc_pkg::ST_SWEEP;
    endcase
  end

  // Memory ports and mark control
  always_comb begin
    vc_we     = 1'b0;
    vc_waddr  = vtx_q[VAW-1:0];
    vc_wdata  = color_q;
    vc_raddr  = in_data_i.neighbor[VAW-1:0];
    cc_we     = 1'b0;
    cc_waddr  = color_q[CAW-1:0];
    cc_wdata  = new_cnt;
    cc_raddr  = color_q[CAW-1:0];
    mark_ctrl.clr       = 1'b0;
    mark_ctrl.set       = nb_pend_q && (vc_rdata != '0);
    mark_ctrl.set_color = vc_rdata;
    mark_ctrl.find      = 1'b0;
    case (state_q)
      ggc_pkg::ST_SWEEP: begin
        vc_we         = (32'(sweep_q) < NumVert);
        vc_waddr      = sweep_q[VAW-1:0];
        vc_wdata      = '0;
        cc_we         = 1'b1;
        cc_waddr      = sweep_q;
        cc_wdata      = '0;
        mark_ctrl.clr = 1'b1;
      end
      ggc_pkg::ST_IDLE: begin
      end
      ggc_pkg::ST_FIND: begin
        vc_raddr       = vtx_q[VAW-1:0];
        mark_ctrl.find = 1'b1;
        mark_ctrl.clr  = !vtx_ok_q;
      end
      ggc_pkg::ST_READ_OLD: begin
        cc_raddr = vc_rdata[CAW-1:0];
      end
      ggc_pkg::ST_UPD_OLD: begin
        vc_we    = 1'b1;
        cc_we    = dec_ok;
        cc_waddr = old_q[CAW-1:0];
        cc_wdata = cc_rdata - CW'(1);
      end
      ggc_pkg::ST_UPD_NEW: begin
        cc_we         = finish;
        mark_ctrl.clr = finish;
      end
      default: begin
      end
    endcase
  end

  assign sweep_d = (state_q == ggc_pkg::ST_SWEEP && sweep_q != SweepLast)
                 ? sweep_q + CAW'(1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ggc_pkg::ST_SWEEP;
      sweep_q     <= '0;
      nb_pend_q   <= 1'b0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      nb_pend_q <= accept && (in_data_i.cmd == ggc_pkg::CMD_NEIGHBOR) && nb_ok;
      if (state_q == ggc_pkg::ST_SWEEP) begin
        max_q <= '0;
      end else if (state_q == ggc_pkg::ST_UPD_NEW && finish) begin
        max_q <= max_new;
      end
      if (state_q == ggc_pkg::ST_UPD_NEW && finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.cmd == ggc_pkg::CMD_ASSIGN) begin
      vtx_q    <= in_data_i.vertex;
      vtx_ok_q <= 32'(in_data_i.vertex) < MaxV;
    end
    if (state_q == ggc_pkg::ST_READ_OLD) begin
      old_q   <= vc_rdata;
      color_q <= free_color;
    end
    if (state_q == ggc_pkg::ST_UPD_OLD) begin
      dec_q <= cc_rdata - CW'(1);
      fwd_q <= dec_ok && (old_q == color_q);
    end
    if (state_q == ggc_pkg::ST_UPD_NEW && finish) begin
      out_q.colored_vertex <= vtx_q;
      out_q.color          <= color_q;
      out_q.color_count    <= new_cnt;
      out_q.colors_used    <= max_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ggc_ram #(
    .WIDTH (CW),
    .DEPTH (NumVert)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (vc_we),
    .waddr_i (vc_waddr),
    .wdata_i (vc_wdata),
    .raddr_i (vc_raddr),
    .rdata_o (vc_rdata)
  );

  ggc_ram #(
    .WIDTH (CW),
    .DEPTH (NumColors)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cc_we),
    .waddr_i (cc_waddr),
    .wdata_i (cc_wdata),
    .raddr_i (cc_raddr),
    .rdata_o (cc_rdata)
  );

  ggc_marks #(
    .NUM_VERTICES (NumVert)
  ) u_marks (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mark_ctrl),
    .free_color_o (free_color)
  );

  `GGC_ASSERT(a_result_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ggc_pkg::ST_UPD_NEW)
  `GGC_ASSERT(a_result_sane, clk_i, rst_ni, out_valid_q |-> (out_q.color != '0) && (out_q.color_count != '0) && (out_q.colors_used >= out_q.color))
  `GGC_ASSERT(a_sweep_done, clk_i, rst_ni, (state_q == ggc_pkg::ST_SWEEP && sweep_q == SweepLast) |=> state_q == ggc_pkg::ST_IDLE)
  `GGC_ASSERT_NEVER(a_sweep_idle, clk_i, rst_ni, state_q != ggc_pkg::ST_SWEEP && sweep_q != '0)

endmodule

// ===== hdl/ggc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ggc_marks.sv =====
// ----------------------------------------------------------------------------
// Greedy graph coloring used-color marks
// One flag per color and a two-stage first-free search in 16-color groups.
// ----------------------------------------------------------------------------
module ggc_marks #(
  parameter int NUM_VERTICES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ggc_pkg::mark_ctrl_t           ctrl_i,
  output logic [ggc_pkg::ColorW-1:0]    free_color_o
);

  localparam int unsigned NumColors = NUM_VERTICES + 2;
  localparam int unsigned IdxW      = $clog2(NumColors);
  localparam int unsigned NumGroups = (NumColors + ggc_pkg::GroupW - 1) / ggc_pkg::GroupW;
  localparam int unsigned GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int unsigned PadW      = NumGroups * ggc_pkg::GroupW;
  localparam int unsigned BitW      = $clog2(ggc_pkg::GroupW);

  logic [NumColors-1:0]        marks_q;
  logic [PadW-1:0]             marks_pad;
  logic [PadW-1:0]             free_vec;
  logic [GrpW-1:0]             grp_d, grp_q;
  logic [ggc_pkg::GroupW-1:0]  bits_d, bits_q;
  logic [BitW-1:0]             bit_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else if (ctrl_i.clr) begin
      marks_q <= '0;
    end else if (ctrl_i.set && (32'(ctrl_i.set_color) < NumColors)) begin
      marks_q[ctrl_i.set_color[IdxW-1:0]] <= 1'b1;
    end
  end

  assign marks_pad = PadW'(marks_q);

  // Color 0 never counts; the color just past the vertex count is always free.
  always_comb begin
    for (int i = 0; i < PadW; i++) begin
      free_vec[i] = ((i >= 1) && (i <= NUM_VERTICES) && !marks_pad[i])
                 || (i == NUM_VERTICES + 1);
    end
  end

  always_comb begin
    grp_d = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (|free_vec[g*ggc_pkg::GroupW +: ggc_pkg::GroupW]) begin
        grp_d = GrpW'(g);
      end
    end
    bits_d = free_vec[grp_d*ggc_pkg::GroupW +: ggc_pkg::GroupW];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.find) begin
      grp_q  <= grp_d;
      bits_q <= bits_d;
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int b = ggc_pkg::GroupW - 1; b >= 0; b--) begin
      if (bits_q[b]) begin
        bit_idx = BitW'(b);
      end
    end
  end

  assign free_color_o = ggc_pkg::ColorW'({grp_q, bit_idx});

endmodule

// ===== tb/tb_greedy_graph_coloring.sv =====
// ----------------------------------------------------------------------------
// Greedy graph coloring testbench
// Drives directed and random vertex sequences (neighbor runs closed by an
// assign, clears, ignored commands) with random idle and stall bursts, and
// checks every result against an in-bench first-fit coloring predictor.
// ----------------------------------------------------------------------------
module tb_greedy_graph_coloring;
  timeunit 1ns;
  timeprecision 1ps;

  import ggc_pkg::*;

  localparam int unsigned NumVertices = 256;
  localparam int unsigned NumColors   = NumVertices + 2;
  localparam int unsigned RandomItems = 650;
  localparam int unsigned CalmTail    = 60;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 16;

  localparam logic [CmdW-1:0] CmdIgnored = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  greedy_graph_coloring dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  in_item_t  pending_items[$];
  out_item_t expected_colorings[$];

  // First-fit state kept by the bench
  logic [ColorW-1:0] color_of [NumVertices];
  bit                color_taken [NumColors];
  logic [ColorW-1:0] holders_of [NumColors];
  logic [ColorW-1:0] top_color;

  logic in_taken   = 1'b0;
  int   send_gap   = 0;
  int   stall_left = 0;
  int   idle_run   = 0;
  int   err_count  = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void wipe_graph();
    for (int i = 0; i < NumVertices; i++) color_of[i] = '0;
    for (int i = 0; i < NumColors; i++) begin
      color_taken[i] = 1'b0;
      holders_of[i]  = '0;
    end
    top_color = '0;
  endfunction

  function automatic void first_fit_step(input in_item_t it);
    logic [ColorW-1:0] nc;
    logic [ColorW-1:0] old;
    logic [ColorW-1:0] c;
    out_item_t         res;
    case (it.cmd)
      CMD_CLEAR: begin
        wipe_graph();
      end
      CMD_NEIGHBOR: begin
        nc = color_of[it.neighbor];
        if (nc != 0 && nc < NumColors) color_taken[nc] = 1'b1;
      end
      CMD_ASSIGN: begin
        c = ColorW'(1);
        while (c < NumVertices + 1 && color_taken[c]) c++;
        old = color_of[it.vertex];
        if (old != 0 && old < NumColors && holders_of[old] != 0) holders_of[old]--;
        color_of[it.vertex] = c;
        if (holders_of[c] != CountMax) holders_of[c]++;
        if (c > top_color) top_color = c;
        res.colored_vertex = it.vertex;
        res.color          = c;
        res.color_count    = holders_of[c];
        res.colors_used    = top_color;
        expected_colorings.push_back(res);
        for (int i = 0; i < NumColors; i++) color_taken[i] = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic add_item(input logic [CmdW-1:0] c, input logic [VtxW-1:0] v,
                          input logic [VtxW-1:0] n);
    in_item_t it;
    it.cmd      = c;
    it.vertex   = v;
    it.neighbor = n;
    pending_items.push_back(it);
  endtask

  // Check results and predict on transfers, all sampled at the rising edge
  always @(posedge clk_i) begin : monitor
    out_item_t exp_res;
    bit        in_xfer;
    bit        out_xfer;
    if (rst_ni) begin
      in_xfer  = in_valid_i && !in_stall_o;
      out_xfer = out_valid_o && !out_stall_i;
      if (out_xfer) begin
        if (expected_colorings.size() == 0) begin
          $error("result with nothing expected: vertex %0d color %0d",
                 out_data_o.colored_vertex, out_data_o.color);
          err_count++;
        end else begin
          exp_res = expected_colorings.pop_front();
          if (out_data_o.colored_vertex !== exp_res.colored_vertex) begin
            $error("colored_vertex: expected %0d, got %0d",
                   exp_res.colored_vertex, out_data_o.colored_vertex);
            err_count++;
          end
          if (out_data_o.color !== exp_res.color) begin
            $error("color: expected %0d, got %0d", exp_res.color, out_data_o.color);
            err_count++;
          end
          if (out_data_o.color_count !== exp_res.color_count) begin
            $error("color_count: expected %0d, got %0d",
                   exp_res.color_count, out_data_o.color_count);
            err_count++;
          end
          if (out_data_o.colors_used !== exp_res.colors_used) begin
            $error("colors_used: expected %0d, got %0d",
                   exp_res.colors_used, out_data_o.colors_used);
            err_count++;
          end
        end
      end
      if (in_xfer) first_fit_step(in_data_i);
      in_taken <= in_xfer;
      if (in_xfer || out_xfer) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Drive both handshakes at the falling edge
  always @(negedge clk_i) begin : driver
    logic     nxt_valid;
    in_item_t nxt_data;
    bit       calm;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      nxt_data  = in_data_i;
      calm      = pending_items.size() < CalmTail;
      // hold the payload until its transfer
      if (!in_valid_i || in_taken) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 8);
        end else if (pending_items.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = pending_items.pop_front();
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i  <= nxt_data;
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 8);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int              made;
    int              pick;
    int              nn;
    int              k;
    logic [VtxW-1:0] v;
    logic [VtxW-1:0] placed[$];

    wipe_graph();

    // Directed: first colors, self neighbor, recoloring, uncolored neighbor,
    // ignored command, marks dropped by a clear
    add_item(CMD_CLEAR, 8'hFF, 8'hFF);
    add_item(CMD_ASSIGN, 8'd0, 8'hFF);
    add_item(CMD_NEIGHBOR, 8'hFF, 8'd0);
    add_item(CMD_ASSIGN, 8'd255, 8'd0);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd255);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd0);
    add_item(CMD_ASSIGN, 8'd255, 8'hFF);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd17);
    add_item(CMD_ASSIGN, 8'd17, 8'd0);
    add_item(CmdIgnored, 8'hFF, 8'hFF);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd0);
    add_item(CmdIgnored, 8'd0, 8'd255);
    add_item(CMD_ASSIGN, 8'd128, 8'hFF);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd0);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd255);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd128);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd17);
    add_item(CMD_ASSIGN, 8'd0, 8'd0);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd255);
    add_item(CMD_CLEAR, 8'd0, 8'd0);
    add_item(CMD_NEIGHBOR, 8'd0, 8'd0);
    add_item(CMD_ASSIGN, 8'd0, 8'd0);

    // Random: mostly well-formed vertex runs, some cliques to push colors up
    made = 0;
    add_item(CMD_CLEAR, VtxW'($urandom), VtxW'($urandom));
    while (made < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        add_item(CMD_CLEAR, VtxW'($urandom), VtxW'($urandom));
        placed.delete();
        made++;
      end else if (pick < 6) begin
        add_item(CmdIgnored, VtxW'($urandom), VtxW'($urandom));
        made++;
      end else if (pick < 8) begin
        // abandon a neighbor run with a clear
        nn = $urandom_range(1, 3);
        for (int i = 0; i < nn; i++)
          add_item(CMD_NEIGHBOR, VtxW'($urandom), VtxW'($urandom));
        add_item(CMD_CLEAR, VtxW'($urandom), VtxW'($urandom));
        placed.delete();
        made += nn + 1;
      end else begin
        v = ($urandom_range(0, 3) == 0) ? VtxW'($urandom_range(0, 255))
                                        : VtxW'($urandom_range(0, 47));
        if (placed.size() > 0 && $urandom_range(0, 4) == 0) begin
          k  = $urandom_range(4, 16);
          nn = (k < placed.size()) ? k : placed.size();
          for (int i = 0; i < nn; i++)
            add_item(CMD_NEIGHBOR, VtxW'($urandom), placed[placed.size() - 1 - i]);
        end else begin
          nn = $urandom_range(0, 6);
          for (int i = 0; i < nn; i++) begin
            k = $urandom_range(0, 9);
            if (k < 7 && placed.size() > 0)
              add_item(CMD_NEIGHBOR, VtxW'($urandom),
                       placed[$urandom_range(0, placed.size() - 1)]);
            else if (k == 7)
              add_item(CMD_NEIGHBOR, VtxW'($urandom), v);
            else
              add_item(CMD_NEIGHBOR, VtxW'($urandom), VtxW'($urandom));
          end
        end
        add_item(CMD_ASSIGN, v, VtxW'($urandom));
        placed.push_back(v);
        made += nn + 1;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_colorings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
